>>> hw/rtl/dcab_pkg.sv
// Shared types and constants for the dual-channel ADC block averager.
// No dependencies; used by every module of the block.
package dcab_pkg;

  // Input sample width and samples summed per block
  localparam int SAMPLE_BITS   = 10;
  localparam int BLOCK_SAMPLES = 64;

  // Accumulator, counter and derived widths
  localparam int SUM_BITS   = 16;
  localparam int COUNT_BITS = 6;
  localparam int GAIN_BITS  = 16;
  localparam int OFFS_BITS  = 18;
  localparam int CFG_BITS   = 18;
  localparam int PROD_BITS  = SUM_BITS + GAIN_BITS;
  localparam int SHIFT      = 8;
  localparam int TEMP_BITS  = 25;

  // Configuration register reset values
  localparam logic [GAIN_BITS-1:0] EXT_GAIN_RST   = 16'd98;
  localparam logic [OFFS_BITS-1:0] EXT_OFFSET_RST = 18'd7302;
  localparam logic [GAIN_BITS-1:0] INT_GAIN_RST   = 16'd1092;
  localparam logic [OFFS_BITS-1:0] INT_OFFSET_RST = 18'd67000;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_EXT_GAIN   = 2'd0,
    REG_EXT_OFFSET = 2'd1,
    REG_INT_GAIN   = 2'd2,
    REG_INT_OFFSET = 2'd3
  } cfg_index_t;

  // Channel codes
  localparam logic CH_EXT = 1'b0;
  localparam logic CH_INT = 1'b1;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Classified item handed from front to back
  typedef struct packed {
    logic                next_channel;
    logic                block_done;
    logic                done_channel;
    logic [SUM_BITS-1:0] ext_raw;
    logic [SUM_BITS-1:0] int_raw;
  } item_t;

  // Configuration register file contents
  typedef struct packed {
    logic [GAIN_BITS-1:0] ext_gain;
    logic [OFFS_BITS-1:0] ext_offset;
    logic [GAIN_BITS-1:0] int_gain;
    logic [OFFS_BITS-1:0] int_offset;
  } cfg_t;

endpackage

>>> hw/rtl/dual_channel_adc_block_average_top.sv
// Dual-channel ADC block averager, top level.
// A result passes from its sample transfer through the queue, stage one and the output register.
// Throughput: one sample per cycle while the output is not held, through a four-entry queue and two back stages.
// Reset (synchronous, rst high) clears sums, count and channel to external,
// empties the queue and restores the default gains and offsets.
// Depends on dcab_pkg, dcab_front, dcab_queue, dcab_back.
module dual_channel_adc_block_average_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write_en,
  input  logic [1:0]                             cfg_index,
  input  logic [dcab_pkg::CFG_BITS-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [dcab_pkg::SAMPLE_BITS-1:0]       sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   next_channel,
  output logic                                   block_done,
  output logic                                   done_channel,
  output logic signed [dcab_pkg::TEMP_BITS-1:0]  ext_temp,
  output logic signed [dcab_pkg::TEMP_BITS-1:0]  int_temp
);

  dcab_pkg::item_t front_item;
  dcab_pkg::item_t q_item;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            in_xfer;

  // Sample transfer whenever the queue has room
  assign in_ready = !q_full;
  assign in_xfer  = in_valid && in_ready;

  dcab_front u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (in_xfer),
    .sample (sample),
    .item   (front_item)
  );

  dcab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  dcab_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_channel (next_channel),
    .block_done   (block_done),
    .done_channel (done_channel),
    .ext_temp     (ext_temp),
    .int_temp     (int_temp)
  );

endmodule

>>> hw/rtl/dcab_front.sv
// Front end: accumulates samples, closes blocks and toggles the channel.
// Depends on dcab_pkg.
module dcab_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [dcab_pkg::SAMPLE_BITS-1:0]    sample,
  output dcab_pkg::item_t                     item
);

  logic [dcab_pkg::SUM_BITS-1:0]   running_sum;
  logic [dcab_pkg::COUNT_BITS-1:0] sample_count;
  logic                            active_channel;
  logic [dcab_pkg::SUM_BITS-1:0]   ext_raw_sum;
  logic [dcab_pkg::SUM_BITS-1:0]   int_raw_sum;

  logic [dcab_pkg::SUM_BITS-1:0]   sum_next;
  logic [dcab_pkg::COUNT_BITS:0]   cnt_inc;
  logic                            closing;

  // Sum wraps modulo 2^16; count carries one extra bit for the compare
  assign sum_next = running_sum
                  + dcab_pkg::SUM_BITS'(sample);
  assign cnt_inc  = {1'b0, sample_count} + 1'b1;
  assign closing  = (cnt_inc >= (dcab_pkg::COUNT_BITS+1)'(dcab_pkg::BLOCK_SAMPLES));

  // Block state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      sample_count   <= '0;
      active_channel <= dcab_pkg::CH_EXT;
      ext_raw_sum    <= '0;
      int_raw_sum    <= '0;
    end else if (take) begin
      if (closing) begin
        if (active_channel == dcab_pkg::CH_EXT) begin
          ext_raw_sum <= sum_next;
        end else begin
          int_raw_sum <= sum_next;
        end
        active_channel <= ~active_channel;
        running_sum    <= '0;
        sample_count   <= '0;
      end else begin
        running_sum  <= sum_next;
        sample_count <= cnt_inc[dcab_pkg::COUNT_BITS-1:0];
      end
    end
  end

  // Item as it stands after this sample
  always_comb begin
    item.block_done   = closing;
    item.done_channel = closing ? active_channel : dcab_pkg::CH_EXT;
    item.next_channel = closing ? ~active_channel : active_channel;
    item.ext_raw      = (closing && active_channel == dcab_pkg::CH_EXT) ? sum_next
                                                                       : ext_raw_sum;
    item.int_raw      = (closing && active_channel == dcab_pkg::CH_INT) ? sum_next
                                                                       : int_raw_sum;
  end

endmodule

>>> hw/rtl/dcab_queue.sv
// Short FIFO that decouples the front end from the scaling back end.
// Depends on dcab_pkg.
module dcab_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dcab_pkg::item_t push_item,
  input  logic            pop,
  output dcab_pkg::item_t pop_item,
  output logic            full,
  output logic            empty
);

  dcab_pkg::item_t                 slots [dcab_pkg::QUEUE_DEPTH];
  logic [dcab_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [dcab_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [dcab_pkg::QPTR_BITS:0]    fill;

  assign full     = (fill == (dcab_pkg::QPTR_BITS+1)'(dcab_pkg::QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_item = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

>>> hw/rtl/dcab_back.sv
// Back end: configuration registers and the two-stage temperature scaling.
// Multiply in stage one, shift and subtract offset into the output register.
// Depends on dcab_pkg.
module dcab_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [1:0]                        cfg_index,
  input  logic [dcab_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                              q_empty,
  input  dcab_pkg::item_t                   q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              next_channel,
  output logic                              block_done,
  output logic                              done_channel,
  output logic signed [dcab_pkg::TEMP_BITS-1:0] ext_temp,
  output logic signed [dcab_pkg::TEMP_BITS-1:0] int_temp
);

  dcab_pkg::cfg_t cfg;

  // Stage one registers
  logic                             s1_valid;
  logic                             s1_next_ch;
  logic                             s1_done;
  logic                             s1_done_ch;
  logic [dcab_pkg::PROD_BITS-1:0]   s1_ext_prod;
  logic [dcab_pkg::PROD_BITS-1:0]   s1_int_prod;

  logic s1_take;
  logic s2_load;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ext_gain   <= dcab_pkg::EXT_GAIN_RST;
      cfg.ext_offset <= dcab_pkg::EXT_OFFSET_RST;
      cfg.int_gain   <= dcab_pkg::INT_GAIN_RST;
      cfg.int_offset <= dcab_pkg::INT_OFFSET_RST;
    end else if (cfg_write_en) begin
      unique case (dcab_pkg::cfg_index_t'(cfg_index))
        dcab_pkg::REG_EXT_GAIN:   cfg.ext_gain   <= cfg_data[dcab_pkg::GAIN_BITS-1:0];
        dcab_pkg::REG_EXT_OFFSET: cfg.ext_offset <= cfg_data[dcab_pkg::OFFS_BITS-1:0];
        dcab_pkg::REG_INT_GAIN:   cfg.int_gain   <= cfg_data[dcab_pkg::GAIN_BITS-1:0];
        dcab_pkg::REG_INT_OFFSET: cfg.int_offset <= cfg_data[dcab_pkg::OFFS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stall control: each stage moves when the one after it has room
  assign s2_load = s1_valid && (!out_valid || out_ready);
  assign s1_take = !s1_valid || s2_load;
  assign q_pop   = !q_empty && s1_take;

  // Stage one: products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_next_ch  <= q_item.next_channel;
      s1_done     <= q_item.block_done;
      s1_done_ch  <= q_item.done_channel;
      s1_ext_prod <= dcab_pkg::PROD_BITS'(q_item.ext_raw) * dcab_pkg::PROD_BITS'(cfg.ext_gain);
      s1_int_prod <= dcab_pkg::PROD_BITS'(q_item.int_raw) * dcab_pkg::PROD_BITS'(cfg.int_gain);
    end
  end

  // Stage two: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      next_channel <= s1_next_ch;
      block_done   <= s1_done;
      done_channel <= s1_done_ch;
      ext_temp     <= $signed({1'b0, s1_ext_prod[dcab_pkg::PROD_BITS-1:dcab_pkg::SHIFT]})
                    - $signed(dcab_pkg::TEMP_BITS'(cfg.ext_offset));
      int_temp     <= $signed({1'b0, s1_int_prod[dcab_pkg::PROD_BITS-1:dcab_pkg::SHIFT]})
                    - $signed(dcab_pkg::TEMP_BITS'(cfg.int_offset));
    end
  end

endmodule
